@@ sv/hmdp_pkg.sv @@
package hmdp_pkg;

  // image and depth limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH_BITS = 24;

  // derived sizes
  localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int STORE_DEPTH = (MAX_WIDTH * MAX_HEIGHT * 4) / 3 + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = $clog2(MAX_DIM) + 1;
  localparam int LEVELS_MAX  = $clog2(MAX_DIM) + 1;
  localparam int LVL_W       = 4;
  localparam int CFG_W       = 9;
  localparam int COORD_W     = 8;

  // request and result codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_READ    = 1'b1;
  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // register indexes
  localparam logic [1:0] REG_BASE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_BASE_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_BLD_RD,
    ST_BLD_WR,
    ST_DONE
  } st_t;

  // one store access per cycle: a write and a read
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DEPTH_BITS-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;
  } store_req_t;

  // next coarser dimension, floor of one
  function automatic logic [DIM_W-1:0] half_dim(input logic [DIM_W-1:0] d);
    half_dim = (d > DIM_W'(1)) ? (d >> 1) : DIM_W'(1);
  endfunction

endpackage

@@ sv/hmdp_store.sv @@
module hmdp_store import hmdp_pkg::*; (
  input  logic                  clk,
  input  store_req_t            req,
  output logic [DEPTH_BITS-1:0] rdata
);

  logic [DEPTH_BITS-1:0] mem [STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

@@ sv/hierarchical_min_depth_pyramid.sv @@
// channel   handshake             payload
// in        in_valid / in_stall   opcode, sample_depth, col, row, level
// out       out_valid / out_stall kind, read_depth, level_count
// cfg       cfg_write             cfg_index, cfg_data
//
// a load request writes the store when taken; a read request passes the store's
// registered read port and the output register; the last load starts the build:
// per coarse texel four store reads through the single read port and one write,
// then the completion result; rst is synchronous active high, store not cleared
// a pending result does not block loads; a read or a build end waits for out

module hierarchical_min_depth_pyramid import hmdp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [DEPTH_BITS-1:0] sample_depth,
  input  logic [COORD_W-1:0]    col,
  input  logic [COORD_W-1:0]    row,
  input  logic [LVL_W-1:0]      level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  kind,
  output logic [DEPTH_BITS-1:0] read_depth,
  output logic [LVL_W-1:0]      level_count
);

  st_t state, state_next;

  logic [CFG_W-1:0]      base_width, base_height;
  logic [DIM_W-1:0]      w, h;
  logic [COORD_W-1:0]    load_col, load_row;
  logic [ADDR_W-1:0]     load_addr;
  logic [LVL_W-1:0]      levels_built;

  logic [LVL_W-1:0]      bk;
  logic [COORD_W-1:0]    bx, by;
  logic [DIM_W-1:0]      cw, ch, pw, ph;
  logic [ADDR_W-1:0]     poff, coff;
  logic [1:0]            phase;
  logic [DEPTH_BITS-1:0] acc;
  logic [ADDR_W-1:0]     off_tab [LEVELS_MAX];

  store_req_t            req;
  logic [DEPTH_BITS-1:0] rdata;

  logic accept, out_free, load_last_col, load_last_row, build_trivial;
  logic tex_last, lvl_last;
  logic [DEPTH_BITS-1:0] tex_min;

  // effective image size
  always_comb begin
    if (base_width == '0) w = DIM_W'(1);
    else if (base_width > CFG_W'(MAX_WIDTH)) w = DIM_W'(MAX_WIDTH);
    else w = DIM_W'(base_width);
    if (base_height == '0) h = DIM_W'(1);
    else if (base_height > CFG_W'(MAX_HEIGHT)) h = DIM_W'(MAX_HEIGHT);
    else h = DIM_W'(base_height);
  end

  assign out_free      = !out_valid || !out_stall;
  assign accept        = in_valid && !in_stall;
  assign load_last_col = ({1'b0, load_col} + DIM_W'(1)) >= w;
  assign load_last_row = ({1'b0, load_row} + DIM_W'(1)) >= h;
  assign build_trivial = (w == DIM_W'(1)) && (h == DIM_W'(1));
  assign tex_last      = ({1'b0, bx} == cw - DIM_W'(1)) && ({1'b0, by} == ch - DIM_W'(1));
  assign lvl_last      = (cw == DIM_W'(1)) && (ch == DIM_W'(1));
  assign tex_min       = (rdata < acc) ? rdata : acc;

  // read request address
  logic [LVL_W-1:0]     rd_lvl;
  logic [DIM_W-1:0]     rd_lw, rd_lh, rd_c, rd_r;
  logic [ADDR_W-1:0]    rd_addr;
  always_comb begin
    rd_lvl = (level > levels_built - LVL_W'(1)) ? levels_built - LVL_W'(1) : level;
    rd_lw  = ((w >> rd_lvl) == '0) ? DIM_W'(1) : (w >> rd_lvl);
    rd_lh  = ((h >> rd_lvl) == '0) ? DIM_W'(1) : (h >> rd_lvl);
    rd_c   = ({1'b0, col} > rd_lw - DIM_W'(1)) ? rd_lw - DIM_W'(1) : {1'b0, col};
    rd_r   = ({1'b0, row} > rd_lh - DIM_W'(1)) ? rd_lh - DIM_W'(1) : {1'b0, row};
    rd_addr = ((rd_lvl == '0) ? ADDR_W'(0) : off_tab[rd_lvl])
            + ADDR_W'(rd_r * rd_lw) + ADDR_W'(rd_c);
  end

  // build source and destination texel addresses, source clamped to the level below
  logic [DIM_W-1:0]  src_x, src_y;
  logic [ADDR_W-1:0] src_addr, dst_addr;
  always_comb begin
    src_x = {bx, phase[0]};
    src_y = {by, phase[1]};
    if (src_x > pw - DIM_W'(1)) src_x = pw - DIM_W'(1);
    if (src_y > ph - DIM_W'(1)) src_y = ph - DIM_W'(1);
    src_addr = poff + ADDR_W'(src_y * pw) + ADDR_W'(src_x);
    dst_addr = coff + ADDR_W'({1'b0, by} * cw) + ADDR_W'(bx);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_READ) begin
          state_next = ST_RD_WAIT;
        end else if (accept && load_last_col && load_last_row) begin
          state_next = build_trivial ? ST_DONE : ST_BLD_RD;
        end
      end
      ST_RD_WAIT: state_next = ST_IDLE;
      ST_BLD_RD:  if (phase == 2'd3) state_next = ST_BLD_WR;
      ST_BLD_WR:  if (tex_last && lvl_last) state_next = ST_DONE;
                  else state_next = ST_BLD_RD;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // handshake and store requests
  always_comb begin
    in_stall  = 1'b1;
    req.we    = 1'b0;
    req.waddr = load_addr;
    req.wdata = sample_depth;
    req.raddr = rd_addr;
    case (state)
      ST_IDLE: begin
        in_stall = (opcode == OP_READ) && !out_free;
        req.we   = accept && opcode == OP_LOAD;
      end
      ST_BLD_RD: req.raddr = src_addr;
      ST_BLD_WR: begin
        req.we    = 1'b1;
        req.waddr = dst_addr;
        req.wdata = tex_min;
      end
      default: ;
    endcase
  end

  hmdp_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // configuration, load position and level count
  always_ff @(posedge clk) begin
    if (rst) begin
      base_width   <= CFG_W'(MAX_WIDTH);
      base_height  <= CFG_W'(MAX_HEIGHT);
      load_col     <= '0;
      load_row     <= '0;
      load_addr    <= '0;
      levels_built <= LVL_W'(1);
    end else if (cfg_write && (cfg_index == REG_BASE_WIDTH ||
                               cfg_index == REG_BASE_HEIGHT)) begin
      if (cfg_index == REG_BASE_WIDTH) base_width <= cfg_data;
      else base_height <= cfg_data;
      load_col     <= '0;
      load_row     <= '0;
      load_addr    <= '0;
      levels_built <= LVL_W'(1);
    end else begin
      if (state == ST_IDLE && accept && opcode == OP_LOAD) begin
        if (load_last_col) begin
          load_col <= '0;
          if (load_last_row) begin
            load_row     <= '0;
            load_addr    <= '0;
            levels_built <= LVL_W'(1);
          end else begin
            load_row  <= load_row + COORD_W'(1);
            load_addr <= load_addr + ADDR_W'(1);
          end
        end else begin
          load_col  <= load_col + COORD_W'(1);
          load_addr <= load_addr + ADDR_W'(1);
        end
      end
      if (state == ST_BLD_WR && tex_last && lvl_last) begin
        levels_built <= bk + LVL_W'(1);
      end
    end
  end

  // build sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          phase      <= '0;
          bk         <= LVL_W'(1);
          bx         <= '0;
          by         <= '0;
          pw         <= w;
          ph         <= h;
          cw         <= half_dim(w);
          ch         <= half_dim(h);
          poff       <= '0;
          coff       <= ADDR_W'(w * h);
          off_tab[1] <= ADDR_W'(w * h);
        end
        ST_BLD_RD: begin
          phase <= phase + 2'd1;
          if (phase == 2'd1) acc <= rdata;
          else if (phase != 2'd0) acc <= tex_min;
        end
        ST_BLD_WR: begin
          if (tex_last) begin
            bx   <= '0;
            by   <= '0;
            poff <= coff;
            coff <= coff + ADDR_W'(cw * ch);
            pw   <= cw;
            ph   <= ch;
            cw   <= half_dim(cw);
            ch   <= half_dim(ch);
            bk   <= bk + LVL_W'(1);
            if (!lvl_last) begin
              off_tab[bk + LVL_W'(1)] <= coff + ADDR_W'(cw * ch);
            end
          end else if ({1'b0, bx} == cw - DIM_W'(1)) begin
            bx <= '0;
            by <= by + COORD_W'(1);
          end else begin
            bx <= bx + COORD_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RD_WAIT) begin
      out_valid <= 1'b1;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RD_WAIT) begin
      kind        <= KIND_READ;
      read_depth  <= rdata;
      level_count <= levels_built;
    end else if (state == ST_DONE && out_free) begin
      kind        <= KIND_DONE;
      read_depth  <= '0;
      level_count <= levels_built;
    end
  end

`ifndef SYNTH
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (accept && state == ST_IDLE && opcode == OP_READ) |-> ##2 out_valid)
    else $error("read request produced no result");

  a_levels_range: assert property (@(posedge clk) disable iff (rst)
    (levels_built != '0) && (levels_built <= LVL_W'(LEVELS_MAX)))
    else $error("level count out of range");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_WAIT || state == ST_DONE) |-> !req.we)
    else $error("store written outside load or build");

  a_build_blocks_in: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLD_RD || state == ST_BLD_WR) |-> in_stall)
    else $error("request taken during build");
`endif

endmodule
